// ----- hw/rtl/dtt_pkg.sv -----
// dtt_pkg: shared types and constants for the dual tone timer.
// Used by dtt_div and dual_tone_timer_with_duration_unit; depends on nothing.
package dtt_pkg;

    // default core clock feeding the prescalers
    localparam int unsigned CLOCK_HZ_DEF = 16000000;

    // item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_SILENCE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // prescalers as log2 values: music 1,8,64,256,1024 / effect 1,8,32,64,128,256,1024
    localparam int MUSIC_SCALES  = 5;
    localparam int EFFECT_SCALES = 7;
    localparam int MUSIC_SHIFT  [MUSIC_SCALES]  = '{0, 3, 6, 8, 10};
    localparam int EFFECT_SHIFT [EFFECT_SCALES] = '{0, 3, 5, 6, 7, 8, 10};

    // largest quotient that still fits once one is taken off
    localparam logic [31:0] MUSIC_Q_MAX  = 32'd65536;
    localparam logic [31:0] EFFECT_Q_MAX = 32'd256;

    // effect channel fallback when no prescaler fits
    localparam logic [2:0] EFFECT_FB_IDX = 3'd6;
    localparam logic [7:0] EFFECT_FB_CMP = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SEL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hw/rtl/dtt_div.sv -----
// dtt_div: bit-serial restoring divider, constant clock over a 16-bit divisor.
// Depends on dtt_pkg (t_div_stat).
module dtt_div #(
    parameter int unsigned CLOCK_HZ = dtt_pkg::CLOCK_HZ_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [15:0]                        i_divisor,
    output logic [$clog2(CLOCK_HZ + 1)-1:0]    o_quotient,
    output dtt_pkg::t_div_stat                 o_stat
);
    import dtt_pkg::*;

    localparam int QW = $clog2(CLOCK_HZ + 1);
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] DIVIDEND = QW'(CLOCK_HZ);

    logic [QW-1:0] r_num, n_num;
    logic [QW-1:0] r_quo, n_quo;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [16:0]   w_trial;
    logic          w_ge;

    // one quotient bit per cycle, MSB first
    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = DIVIDEND;
            n_rem  = '0;
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            n_quo = {r_quo[QW-2:0], w_ge};
            n_rem = w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finishing pass");

endmodule

// ----- hw/rtl/dual_tone_timer_with_duration_unit.sv -----
// dual_tone_timer_with_duration_unit: two-channel tone controller, top level.
// Depends on dtt_pkg and dtt_div.
//
//  channel  | direction | handshake         | word
//  ---------+-----------+-------------------+------------------------------------------
//  command  | in        | i_valid / o_stall | kind, channel, frequency, duration, now
//  settings | out       | o_valid / i_stall | on, prescale, compare for both channels
//
// Flow: a start word with a nonzero frequency goes through ST_EXEC, ST_DIV, ST_SEL and
//   ST_OUT to the settings word; in ST_DIV the bit-serial divider works out CLOCK_HZ /
//   frequency one quotient bit a cycle over QW = clog2(CLOCK_HZ+1) bits (24 at 16 MHz).
// Other words go through ST_EXEC and ST_OUT. The next word is taken once the previous settings
//   word has gone into the output register, even if that register is still stalled.
// Reset (synchronous, active low) clears both channels: off, prescale 0, compare 0,
//   disarmed, deadline 0.
// A stalled settings word holds in the output register; the core waits in ST_OUT.
module dual_tone_timer_with_duration_unit #(
    parameter int unsigned CLOCK_HZ = dtt_pkg::CLOCK_HZ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command word
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_channel,
    input  logic [15:0] i_frequency_hz,
    input  logic [15:0] i_duration_ms,
    input  logic [31:0] i_now_ms,
    // settings word
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_music_on,
    output logic [2:0]  o_music_prescale,
    output logic [15:0] o_music_compare,
    output logic        o_effect_on,
    output logic [2:0]  o_effect_prescale,
    output logic [7:0]  o_effect_compare
);
    import dtt_pkg::*;

    localparam int QW = $clog2(CLOCK_HZ + 1);

    t_state r_state, n_state;

    // captured command word
    logic [1:0]  r_kind;
    logic        r_chan;
    logic [15:0] r_freq;
    logic [15:0] r_dur;
    logic [31:0] r_now;

    // channel state
    logic        r_music_enable, r_music_armed;
    logic [2:0]  r_music_scale_index;
    logic [15:0] r_music_match;
    logic [31:0] r_music_deadline;
    logic        r_effect_enable, r_effect_armed;
    logic [2:0]  r_effect_scale_index;
    logic [7:0]  r_effect_match;
    logic [31:0] r_effect_deadline;

    logic        r_out_valid;

    // control decode
    logic        w_accept, w_div_start, w_load, w_taken;
    logic        w_need_div;
    t_div_stat   w_div_stat;
    logic [QW-1:0] w_quo;

    // deadline checks
    logic [31:0] w_music_diff, w_effect_diff;
    logic        w_music_expire, w_effect_expire;

    // prescaler search results
    logic [QW-1:0] w_m_q, w_e_q;
    logic [2:0]    w_m_sel, w_e_sel;
    logic          w_m_hit, w_e_hit;
    logic [2:0]    w_m_idx, w_e_idx;
    logic [15:0]   w_m_cmp;
    logic [7:0]    w_e_cmp;

    assign w_accept   = i_valid && !o_stall;
    assign w_taken    = r_out_valid && !i_stall;
    assign w_need_div = (r_kind == KIND_START) && (r_freq != '0);

    dtt_div #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (r_freq),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = w_need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (w_div_stat.done) n_state = ST_SEL;
            end
            ST_SEL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        o_stall     = 1'b1;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: o_stall = 1'b0;
            ST_EXEC: w_div_start = w_need_div;
            ST_DIV:  ;
            ST_SEL:  ;
            ST_OUT:  w_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    // Deadline passed when now - deadline is non-negative as a signed 32-bit value.
    assign w_music_diff    = r_now - r_music_deadline;
    assign w_effect_diff   = r_now - r_effect_deadline;
    assign w_music_expire  = r_music_armed && !w_music_diff[31];
    assign w_effect_expire = r_effect_armed && !w_effect_diff[31];

    // Prescaler search. CLOCK/(2*p*f) == (CLOCK/f) >> (log2 p + 1), so one quotient
    // serves every prescaler. Walk from the largest down; each fit overwrites, so the smallest fit wins.
    always_comb begin
        w_m_hit = 1'b0;
        w_m_q   = '0;
        w_m_sel = '0;
        for (int i = MUSIC_SCALES - 1; i >= 0; i--) begin
            if (32'(w_quo >> (MUSIC_SHIFT[i] + 1)) <= MUSIC_Q_MAX) begin
                w_m_hit = 1'b1;
                w_m_q   = w_quo >> (MUSIC_SHIFT[i] + 1);
                w_m_sel = 3'(i);
            end
        end
        w_e_hit = 1'b0;
        w_e_q   = '0;
        w_e_sel = '0;
        for (int i = EFFECT_SCALES - 1; i >= 0; i--) begin
            if (32'(w_quo >> (EFFECT_SHIFT[i] + 1)) <= EFFECT_Q_MAX) begin
                w_e_hit = 1'b1;
                w_e_q   = w_quo >> (EFFECT_SHIFT[i] + 1);
                w_e_sel = 3'(i);
            end
        end
        // a zero quotient wraps on the minus one and counts as no fit
        if (w_m_hit && (w_m_q != '0)) begin
            w_m_idx = w_m_sel;
            w_m_cmp = 16'(w_m_q - 1'b1);
        end else begin
            w_m_idx = '0;
            w_m_cmp = '0;
        end
        if (w_e_hit && (w_e_q != '0)) begin
            w_e_idx = w_e_sel;
            w_e_cmp = 8'(w_e_q - 1'b1);
        end else begin
            w_e_idx = EFFECT_FB_IDX;
            w_e_cmp = EFFECT_FB_CMP;
        end
    end

    // ---- command capture ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_chan <= i_channel;
            r_freq <= i_frequency_hz;
            r_dur  <= i_duration_ms;
            r_now  <= i_now_ms;
        end
    end

    // ---- channel state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state              <= ST_IDLE;
            r_music_enable       <= 1'b0;
            r_music_armed        <= 1'b0;
            r_music_scale_index  <= '0;
            r_music_match        <= '0;
            r_music_deadline     <= '0;
            r_effect_enable      <= 1'b0;
            r_effect_armed       <= 1'b0;
            r_effect_scale_index <= '0;
            r_effect_match       <= '0;
            r_effect_deadline    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                priority if (r_kind == KIND_START) begin
                    // a start arms only for a nonzero duration; frequency zero only switches the output off
                    if (!r_chan) begin
                        r_music_armed    <= (r_dur != '0);
                        r_music_deadline <= r_now + 32'(r_dur);
                        if (r_freq == '0) r_music_enable <= 1'b0;
                    end else begin
                        r_effect_armed    <= (r_dur != '0);
                        r_effect_deadline <= r_now + 32'(r_dur);
                        if (r_freq == '0) r_effect_enable <= 1'b0;
                    end
                end else if (r_kind == KIND_SILENCE) begin
                    if (!r_chan) begin
                        r_music_armed  <= 1'b0;
                        r_music_enable <= 1'b0;
                    end else begin
                        r_effect_armed  <= 1'b0;
                        r_effect_enable <= 1'b0;
                    end
                end else if (r_kind == KIND_TICK) begin
                    if (w_music_expire) begin
                        r_music_armed  <= 1'b0;
                        r_music_enable <= 1'b0;
                    end
                    if (w_effect_expire) begin
                        r_effect_armed  <= 1'b0;
                        r_effect_enable <= 1'b0;
                    end
                end else begin
                    // unused kind: no change
                end
            end
            if (r_state == ST_SEL) begin
                if (!r_chan) begin
                    r_music_enable      <= 1'b1;
                    r_music_scale_index <= w_m_idx;
                    r_music_match       <= w_m_cmp;
                end else begin
                    r_effect_enable      <= 1'b1;
                    r_effect_scale_index <= w_e_idx;
                    r_effect_match       <= w_e_cmp;
                end
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_music_on        <= r_music_enable;
            o_music_prescale  <= r_music_scale_index;
            o_music_compare   <= r_music_match;
            o_effect_on       <= r_effect_enable;
            o_effect_prescale <= r_effect_scale_index;
            o_effect_compare  <= r_effect_match;
        end
    end

    assign o_valid = r_out_valid;

    a_div_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && w_div_stat.done |=> (r_state == ST_SEL))
        else $error("divider result not taken up");

    a_div_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider running outside the divide state");

    a_tick_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) && (r_kind == KIND_TICK) && w_music_expire
        |=> !r_music_enable && !r_music_armed)
        else $error("expired music channel left running");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_music_scale_index <= 3'd4) && (r_effect_scale_index <= EFFECT_FB_IDX))
        else $error("prescale index out of range");

endmodule
